FILE: sv/wts_pkg.sv
// ----------------------------------------------------------------------------
// wts_pkg
// Shared types and fixed constants of the wrap-addressed texture sampler.
// ----------------------------------------------------------------------------
package wts_pkg;

   localparam int COORD_W   = 24;
   localparam int FRAC_BITS = 8;
   localparam int INT_W     = COORD_W - FRAC_BITS;
   localparam int SIDE_W    = 7;
   localparam int MAX_SIDE  = 64;
   localparam int IDX_W     = $clog2(MAX_SIDE);
   localparam int ADDR_W    = IDX_W + SIDE_W;
   localparam int FW_W      = FRAC_BITS + 1;
   localparam int WGT_W     = 2 * FRAC_BITS + 1;
   localparam int ACC_W     = 2 * FRAC_BITS + 8;
   localparam int LANES     = 4;
   localparam int CNT_W     = $clog2(INT_W);

   localparam logic [FW_W-1:0]  ONE_FRAC   = FW_W'(1) << FRAC_BITS;
   localparam logic [WGT_W-1:0] UNIT_WGT   = WGT_W'(1) << (2 * FRAC_BITS);
   localparam logic [ACC_W:0]   ROUND_HALF = (ACC_W + 1)'(1) << (2 * FRAC_BITS - 1);

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_FILTER = 2'd2;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   localparam logic MODE_NEAREST = 1'b0;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_status_type;

   typedef struct packed {
      logic clear;
      logic accumulate;
   } blend_ctl_type;

endpackage

FILE: sv/wts_texstore.sv
// ----------------------------------------------------------------------------
// wts_texstore
// Single-port texel store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module wts_texstore
   import wts_pkg::*;
#(
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [31:0]              wdata,
   output logic [31:0]              rdata
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/wts_modunit.sv
// ----------------------------------------------------------------------------
// wts_modunit
// Bit-serial modulo unit: signed coordinate mod image side, one bit a cycle,
// result in [0, n) once done.
// ----------------------------------------------------------------------------
module wts_modunit
   import wts_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [INT_W-1:0]  c_in,
   input  logic [SIDE_W-1:0]        n_in,
   output mod_status_type           status,
   output logic [SIDE_W-1:0]        result
);

   logic [INT_W-1:0]  mag_ff,  mag_in;
   logic [SIDE_W-1:0] rem_ff,  rem_in;
   logic [SIDE_W-1:0] n_ff,    n_in_reg;
   logic              neg_ff,  neg_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SIDE_W:0]   trial;

   always_comb begin
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      n_in_reg = n_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      trial    = {rem_ff, mag_ff[INT_W-1]};
      if (start) begin
         mag_in   = c_in[INT_W-1] ? INT_W'(-c_in) : INT_W'(c_in);
         rem_in   = '0;
         n_in_reg = n_in;
         neg_in   = c_in[INT_W-1];
         cnt_in   = '0;
         busy_in  = 1'b1;
         done_in  = 1'b0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, n_ff}) begin
            rem_in = SIDE_W'(trial - {1'b0, n_ff});
         end else begin
            rem_in = SIDE_W'(trial);
         end
         mag_in = {mag_ff[INT_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(INT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      n_ff   <= n_in_reg;
      neg_ff <= neg_in;
   end

   // negative operand: fold truncated remainder back into range
   assign result = (neg_ff && rem_ff != '0) ? SIDE_W'(n_ff - rem_ff) : rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> result < n_ff)
      else $error("modulo result not below divisor");

endmodule

FILE: sv/wts_blend.sv
// ----------------------------------------------------------------------------
// wts_blend
// Four-lane weighted accumulator with half-up rounding to 8 bits.
// ----------------------------------------------------------------------------
module wts_blend
   import wts_pkg::*;
(
   input  logic                       clock,
   input  blend_ctl_type              ctl,
   input  logic [WGT_W-1:0]           weight,
   input  logic [31:0]                texel,
   output logic [LANES-1:0][7:0]      channel
);

   logic [ACC_W-1:0] acc_ff [LANES];
   logic [ACC_W:0]   rounded [LANES];

   always_ff @(posedge clock) begin
      for (int k = 0; k < LANES; k++) begin
         if (ctl.clear) begin
            acc_ff[k] <= '0;
         end else if (ctl.accumulate) begin
            acc_ff[k] <= acc_ff[k] + ACC_W'(ACC_W'(weight) * ACC_W'(texel[8*k +: 8]));
         end
      end
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         rounded[k] = {1'b0, acc_ff[k]} + ROUND_HALF;
         if (rounded[k][ACC_W:2*FRAC_BITS] > (ACC_W + 1 - 2 * FRAC_BITS)'(255)) begin
            channel[k] = 8'hFF;
         end else begin
            channel[k] = rounded[k][2*FRAC_BITS +: 8];
         end
      end
   end

endmodule

FILE: sv/wrap_texture_sampler_unit.sv
// ----------------------------------------------------------------------------
// wrap_texture_sampler_unit
// RGBA8 texture sampler with wrap addressing, nearest or bilinear filtering.
// ----------------------------------------------------------------------------
// A texel write is accepted in idle and the block is ready again at once. A
// bilinear sample holds req_stall through a setup step, then for each of the
// four footprint corners an address multiply, a read of the single-port store
// and an accumulate, and last a step that rounds into the result register. A
// footprint wholly outside the image skips the corners. A nearest sample
// first spends two passes of the 16-step bit-serial modulo unit, which wraps
// the integer coordinates, then reads and accumulates a single texel.
// A finished result waits in the output register while the next request is
// accepted; a further result then waits in the sequencer, stalling input,
// until that register is taken. Texels never written read back undefined.
// ----------------------------------------------------------------------------
module wrap_texture_sampler_unit
   import wts_pkg::*;
#(
   parameter int MAX_TEXELS = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_func,
   input  logic [11:0]               req_texel_index,
   input  logic [31:0]               req_texel_rgba,
   input  logic signed [COORD_W-1:0] req_sample_u,
   input  logic signed [COORD_W-1:0] req_sample_v,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_channel_0,
   output logic [7:0]                rsp_channel_1,
   output logic [7:0]                rsp_channel_2,
   output logic [7:0]                rsp_channel_3,
   output logic                      rsp_outside,
   input  logic                      csr_write,
   input  logic [1:0]                csr_index,
   input  logic [SIDE_W-1:0]         csr_data
);

   localparam int MEM_AW = $clog2(MAX_TEXELS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_MODX  = 3'd2;
   localparam logic [2:0] S_MODY  = 3'd3;
   localparam logic [2:0] S_ADDR  = 3'd4;
   localparam logic [2:0] S_READ  = 3'd5;
   localparam logic [2:0] S_MAC   = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [SIDE_W-1:0] width_ff,  width_in;
   logic [SIDE_W-1:0] height_ff, height_in;
   logic              mode_ff,   mode_in;

   logic [2:0]               state_ff,   state_in;
   logic [COORD_W-1:0]       u_ff,       u_in;
   logic [COORD_W-1:0]       v_ff,       v_in;
   logic [IDX_W-1:0]         x1_ff,      x1_in;
   logic [IDX_W-1:0]         x2_ff,      x2_in;
   logic [IDX_W-1:0]         y1_ff,      y1_in;
   logic [IDX_W-1:0]         y2_ff,      y2_in;
   logic [1:0]               corner_ff,  corner_in;
   logic                     near_ff,    near_in;
   logic                     outside_ff, outside_in;
   logic [ADDR_W-1:0]        addr_ff,    addr_in;
   logic                     inrange_ff, inrange_in;
   logic [WGT_W-1:0]         weight_ff,  weight_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [LANES-1:0][7:0]    rsp_ch_ff,  rsp_ch_in;
   logic                     rsp_out_ff, rsp_out_in;

   logic [SIDE_W-1:0]        w_side, h_side;
   logic                     req_accept, wr_accept, wr_ok;
   logic [31:0]              wr_idx32, rd_idx32;
   logic signed [INT_W:0]    xf, yf, x2s, y2s, ws, hs, x1w, x2w, y1w, y2w;
   logic [FRAC_BITS-1:0]     fu, fv;
   logic                     bil_out;
   logic [IDX_W-1:0]         xs, ys;
   logic [FW_W-1:0]          wa, wb;

   logic                     mod_start;
   logic signed [INT_W-1:0]  mod_c;
   logic [SIDE_W-1:0]        mod_n;
   mod_status_type           mod_stat;
   logic [SIDE_W-1:0]        mod_res;

   logic                     mem_en, mem_we;
   logic [MEM_AW-1:0]        mem_addr;
   logic [31:0]              mem_rdata;

   blend_ctl_type            blend_ctl;
   logic [31:0]              blend_texel;
   logic [LANES-1:0][7:0]    blend_ch;

   // configuration registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      mode_in   = mode_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_WIDTH: begin
               width_in = csr_data;
            end
            CSR_HEIGHT: begin
               height_in = csr_data;
            end
            CSR_FILTER: begin
               mode_in = csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_side = SIDE_W'(1);
      end else if (width_ff > SIDE_W'(MAX_SIDE)) begin
         w_side = SIDE_W'(MAX_SIDE);
      end else begin
         w_side = width_ff;
      end
      if (height_ff == '0) begin
         h_side = SIDE_W'(1);
      end else if (height_ff > SIDE_W'(MAX_SIDE)) begin
         h_side = SIDE_W'(MAX_SIDE);
      end else begin
         h_side = height_ff;
      end
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign wr_accept  = req_accept && (req_func == FUNC_WRITE);
   assign wr_idx32   = 32'(req_texel_index);
   assign wr_ok      = wr_idx32 < 32'(MAX_TEXELS);

   // footprint geometry
   assign fu  = u_ff[FRAC_BITS-1:0];
   assign fv  = v_ff[FRAC_BITS-1:0];
   assign xf  = $signed({u_ff[COORD_W-1], u_ff[COORD_W-1:FRAC_BITS]});
   assign yf  = $signed({v_ff[COORD_W-1], v_ff[COORD_W-1:FRAC_BITS]});
   assign x2s = xf + $signed((INT_W + 1)'(fu != '0));
   assign y2s = yf + $signed((INT_W + 1)'(fv != '0));
   assign ws  = $signed((INT_W + 1)'(w_side));
   assign hs  = $signed((INT_W + 1)'(h_side));
   assign bil_out = x2s[INT_W] || (xf >= ws) || y2s[INT_W] || (yf >= hs);
   assign x1w = xf[INT_W]   ? xf + ws  : xf;
   assign y1w = yf[INT_W]   ? yf + hs  : yf;
   assign x2w = (x2s >= ws) ? x2s - ws : x2s;
   assign y2w = (y2s >= hs) ? y2s - hs : y2s;

   assign xs = corner_ff[0] ? x2_ff : x1_ff;
   assign ys = corner_ff[1] ? y2_ff : y1_ff;
   assign wa = corner_ff[0] ? FW_W'(fu) : ONE_FRAC - FW_W'(fu);
   assign wb = corner_ff[1] ? FW_W'(fv) : ONE_FRAC - FW_W'(fv);
   assign rd_idx32 = 32'(addr_in);

   always_comb begin
      state_in     = state_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      y1_in        = y1_ff;
      y2_in        = y2_ff;
      corner_in    = corner_ff;
      near_in      = near_ff;
      outside_in   = outside_ff;
      addr_in      = addr_ff;
      inrange_in   = inrange_ff;
      weight_in    = weight_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ch_in    = rsp_ch_ff;
      rsp_out_in   = rsp_out_ff;
      mod_start    = 1'b0;
      mod_c        = xf[INT_W-1:0];
      mod_n        = w_side;
      blend_ctl    = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && req_func == FUNC_SAMPLE) begin
               u_in     = req_sample_u;
               v_in     = req_sample_v;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            blend_ctl.clear = 1'b1;
            corner_in       = '0;
            outside_in      = 1'b0;
            if (mode_ff == MODE_NEAREST) begin
               near_in   = 1'b1;
               mod_start = 1'b1;
               state_in  = S_MODX;
            end else if (bil_out) begin
               near_in    = 1'b0;
               outside_in = 1'b1;
               state_in   = S_OUT;
            end else begin
               near_in  = 1'b0;
               x1_in    = x1w[IDX_W-1:0];
               x2_in    = x2w[IDX_W-1:0];
               y1_in    = y1w[IDX_W-1:0];
               y2_in    = y2w[IDX_W-1:0];
               state_in = S_ADDR;
            end
         end
         S_MODX: begin
            if (mod_stat.done) begin
               x1_in     = mod_res[IDX_W-1:0];
               mod_start = 1'b1;
               mod_c     = yf[INT_W-1:0];
               mod_n     = h_side;
               state_in  = S_MODY;
            end
         end
         S_MODY: begin
            if (mod_stat.done) begin
               y1_in    = mod_res[IDX_W-1:0];
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            addr_in    = ADDR_W'(ADDR_W'(ys) * ADDR_W'(w_side)) + ADDR_W'(xs);
            inrange_in = rd_idx32 < 32'(MAX_TEXELS);
            weight_in  = near_ff ? UNIT_WGT : WGT_W'(WGT_W'(wa) * WGT_W'(wb));
            state_in   = S_READ;
         end
         S_READ: begin
            state_in = S_MAC;
         end
         S_MAC: begin
            blend_ctl.accumulate = 1'b1;
            if (near_ff || corner_ff == 2'd3) begin
               state_in = S_OUT;
            end else begin
               corner_in = corner_ff + 2'd1;
               state_in  = S_ADDR;
            end
         end
         S_OUT: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = blend_ch;
               rsp_out_in   = outside_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= SIDE_W'(64);
         height_ff    <= SIDE_W'(64);
         mode_ff      <= 1'b1;
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         mode_ff      <= mode_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      u_ff       <= u_in;
      v_ff       <= v_in;
      x1_ff      <= x1_in;
      x2_ff      <= x2_in;
      y1_ff      <= y1_in;
      y2_ff      <= y2_in;
      corner_ff  <= corner_in;
      near_ff    <= near_in;
      outside_ff <= outside_in;
      addr_ff    <= addr_in;
      inrange_ff <= inrange_in;
      weight_ff  <= weight_in;
      rsp_ch_ff  <= rsp_ch_in;
      rsp_out_ff <= rsp_out_in;
   end

   // single port: writes in idle, corner reads in S_READ
   logic [31:0] addr_ff32;
   assign addr_ff32 = 32'(addr_ff);
   assign mem_we    = wr_accept && wr_ok;
   assign mem_en    = mem_we || (state_ff == S_READ);
   assign mem_addr  = mem_we ? wr_idx32[MEM_AW-1:0] : addr_ff32[MEM_AW-1:0];

   wts_texstore #(
      .DEPTH (MAX_TEXELS)
   ) u_store (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (req_texel_rgba),
      .rdata (mem_rdata)
   );

   wts_modunit u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .c_in   (mod_c),
      .n_in   (mod_n),
      .status (mod_stat),
      .result (mod_res)
   );

   assign blend_texel = inrange_ff ? mem_rdata : '0;

   wts_blend u_blend (
      .clock   (clock),
      .ctl     (blend_ctl),
      .weight  (weight_ff),
      .texel   (blend_texel),
      .channel (blend_ch)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_channel_0 = rsp_ch_ff[0];
   assign rsp_channel_1 = rsp_ch_ff[1];
   assign rsp_channel_2 = rsp_ch_ff[2];
   assign rsp_channel_3 = rsp_ch_ff[3];
   assign rsp_outside   = rsp_out_ff;

   a_last_corner_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC && (near_ff || corner_ff == 2'd3)) |=> state_ff == S_OUT)
      else $error("sequencer did not finish after last corner");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_out_ff) |-> rsp_ch_ff == '0)
      else $error("outside result carries non-zero channels");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !(rsp_valid_ff && rsp_stall))
         |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not loaded into output register");

   a_mod_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MODX || state_ff == S_MODY) |-> (mod_stat.busy || mod_stat.done))
      else $error("waiting on idle modulo unit");

endmodule
